/* src/sync_header_frame_parser_sum16_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the framed packet parser
// Clocked concurrent assertion wrappers, removable with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef SYNC_HEADER_FRAME_PARSER_SUM16_CORE_ASSERT_SVH
`define SYNC_HEADER_FRAME_PARSER_SUM16_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property while out of reset.
`define SHFP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("shfp assertion failed");
// Check a property at every edge, reset included.
`define SHFP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("shfp assertion failed");
`else
`define SHFP_ASSERT(lbl, prop)
`define SHFP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* src/shfp_pkg.sv */
// ---------------------------------------------------------------------------
// shfp_pkg
// Frame layout constants for the framed packet parser.
// ---------------------------------------------------------------------------
`default_nettype none

package shfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 5;

    localparam logic [COUNT_W-1:0] HEADER_LEN = 5'd8;

    // Byte positions inside a frame, header counted.
    localparam logic [COUNT_W-1:0] POS_X_LO    = 5'd8;
    localparam logic [COUNT_W-1:0] POS_X_HI    = 5'd9;
    localparam logic [COUNT_W-1:0] POS_Y_LO    = 5'd10;
    localparam logic [COUNT_W-1:0] POS_Y_HI    = 5'd11;
    localparam logic [COUNT_W-1:0] POS_ANG_LO  = 5'd12;
    localparam logic [COUNT_W-1:0] POS_ANG_HI  = 5'd13;
    localparam logic [COUNT_W-1:0] POS_DIST_LO = 5'd14;
    localparam logic [COUNT_W-1:0] POS_DIST_HI = 5'd15;
    localparam logic [COUNT_W-1:0] POS_SUM_LO  = 5'd16;
    localparam logic [COUNT_W-1:0] POS_SUM_HI  = 5'd17;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;

    // ASCII "tnenoppo"
    localparam t_byte HEADER_CHARS [8] = '{
        8'h74, 8'h6E, 8'h65, 8'h6E, 8'h6F, 8'h70, 8'h70, 8'h6F
    };

endpackage

`default_nettype wire

/* src/sync_header_frame_parser_sum16_core.sv */
// ---------------------------------------------------------------------------
// sync_header_frame_parser_sum16_core
// Byte-stream frame parser with header hunt and 16-bit additive checksum.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data_byte) takes one
//   received byte per transaction. The parser hunts for the header
//   "tnenoppo", then captures x, y, angle and distance (16-bit little
//   endian) and a 16-bit little-endian checksum: 18 bytes per frame.
//   Output channel (o_out_valid / i_out_stall / o_out_*) carries one
//   transaction per completed frame: the checksum flag and the last
//   accepted position, updated only when the checksum matched.
//   Throughput: one byte per cycle, sustained while the output is not
//   stalled; the byte parse is a single 16-bit add and compare between
//   the input register and the result register. Path: the last frame
//   byte is held in the input register, then the result register loads
//   from it; a stall can hold the byte there in between.
//   Stall: while the result register holds an untaken result under
//   i_out_stall, the byte in the input register waits and o_in_stall
//   rises once that register is full; one more byte is still taken.
//   Reset: synchronous, active low; empties both registers, returns to
//   header hunting and clears the accepted position to zero.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sync_header_frame_parser_sum16_core_assert.svh"

module sync_header_frame_parser_sum16_core
    import shfp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_in_data_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_out_checksum_ok,
    output logic signed [15:0]      o_out_pos_x,
    output logic signed [15:0]      o_out_pos_y,
    output logic signed [15:0]      o_out_bearing,
    output logic signed [15:0]      o_out_range_value
);

    // Input register
    logic               r_in_valid;
    t_byte              r_in_byte;

    // Parser state
    logic               r_in_payload, n_in_payload;
    logic [COUNT_W-1:0] r_count, n_count;
    t_word              r_fx, n_fx;
    t_word              r_fy, n_fy;
    t_word              r_fa, n_fa;
    t_word              r_fd, n_fd;
    t_byte              r_sum_lo, n_sum_lo;
    t_word              r_run_sum, n_run_sum;   // sum of the fields seen so far
    t_word              r_acc_x, n_acc_x;
    t_word              r_acc_y, n_acc_y;
    t_word              r_acc_a, n_acc_a;
    t_word              r_acc_d, n_acc_d;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic               r_out_ok, n_out_ok;

    logic               w_blocked;
    logic               w_step;
    logic               w_fire;

    // The result register is occupied and the receiver holds it.
    assign w_blocked  = r_out_valid && i_out_stall;
    assign w_step     = r_in_valid && !w_blocked;
    assign o_in_stall = r_in_valid && w_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_in_data_byte;
        end
    end

    always_comb begin
        n_in_payload = r_in_payload;
        n_count      = r_count;
        n_fx         = r_fx;
        n_fy         = r_fy;
        n_fa         = r_fa;
        n_fd         = r_fd;
        n_sum_lo     = r_sum_lo;
        n_run_sum    = r_run_sum;
        n_acc_x      = r_acc_x;
        n_acc_y      = r_acc_y;
        n_acc_a      = r_acc_a;
        n_acc_d      = r_acc_d;
        n_out_ok     = r_out_ok;
        w_fire       = 1'b0;

        if (w_step) begin
            if (!r_in_payload) begin
                // Hunt: a mismatch drops back to zero, no retry on this byte.
                if ((r_count < HEADER_LEN) && (r_in_byte == HEADER_CHARS[r_count[2:0]])) begin
                    n_count = r_count + 5'd1;
                end else begin
                    n_count = '0;
                end
                if (n_count == HEADER_LEN) begin
                    n_in_payload = 1'b1;
                end
            end else begin
                n_count = r_count + 5'd1;
                case (r_count)
                    POS_X_LO: begin
                        n_fx = {8'h00, r_in_byte};
                    end
                    POS_X_HI: begin
                        n_fx      = {r_in_byte, r_fx[7:0]};
                        n_run_sum = n_fx;
                    end
                    POS_Y_LO: begin
                        n_fy = {8'h00, r_in_byte};
                    end
                    POS_Y_HI: begin
                        n_fy      = {r_in_byte, r_fy[7:0]};
                        n_run_sum = r_run_sum + n_fy;
                    end
                    POS_ANG_LO: begin
                        n_fa = {8'h00, r_in_byte};
                    end
                    POS_ANG_HI: begin
                        n_fa      = {r_in_byte, r_fa[7:0]};
                        n_run_sum = r_run_sum + n_fa;
                    end
                    POS_DIST_LO: begin
                        n_fd = {8'h00, r_in_byte};
                    end
                    POS_DIST_HI: begin
                        n_fd      = {r_in_byte, r_fd[7:0]};
                        n_run_sum = r_run_sum + n_fd;
                    end
                    POS_SUM_LO: begin
                        n_sum_lo = r_in_byte;
                    end
                    POS_SUM_HI: begin
                        // Frame complete: check, maybe accept, report, rehunt.
                        w_fire       = 1'b1;
                        n_out_ok     = (r_run_sum == {r_in_byte, r_sum_lo});
                        n_count      = '0;
                        n_in_payload = 1'b0;
                        if (n_out_ok) begin
                            n_acc_x = r_fx;
                            n_acc_y = r_fy;
                            n_acc_a = r_fa;
                            n_acc_d = r_fd;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_count      <= '0;
            r_fx         <= '0;
            r_fy         <= '0;
            r_fa         <= '0;
            r_fd         <= '0;
            r_sum_lo     <= '0;
            r_run_sum    <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_acc_a      <= '0;
            r_acc_d      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_payload <= n_in_payload;
            r_count      <= n_count;
            r_fx         <= n_fx;
            r_fy         <= n_fy;
            r_fa         <= n_fa;
            r_fd         <= n_fd;
            r_sum_lo     <= n_sum_lo;
            r_run_sum    <= n_run_sum;
            r_acc_x      <= n_acc_x;
            r_acc_y      <= n_acc_y;
            r_acc_a      <= n_acc_a;
            r_acc_d      <= n_acc_d;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload; the accepted registers already hold the frame's outcome.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_ok <= n_out_ok;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_checksum_ok = r_out_ok;
    assign o_out_pos_x       = $signed(r_acc_x);
    assign o_out_pos_y       = $signed(r_acc_y);
    assign o_out_bearing     = $signed(r_acc_a);
    assign o_out_range_value = $signed(r_acc_d);

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `SHFP_ASSERT(a_last_byte_gives_result,
        (w_step && r_in_payload && (r_count == POS_SUM_HI)) |=> o_out_valid)
    `SHFP_ASSERT(a_payload_count_range,
        r_in_payload |-> ((r_count >= HEADER_LEN) && (r_count <= POS_SUM_HI)))
    `SHFP_ASSERT(a_hunt_count_range,
        !r_in_payload |-> (r_count < HEADER_LEN))
    `SHFP_ASSERT_ALWAYS(a_reset_empties_output,
        !i_rst_n |=> (!o_out_valid && !r_in_valid))

endmodule

`default_nettype wire
